/* hw/rtl/cawd_pkg.sv */
// shared types and codes for the cylindrical area weight deposit block
package cawd_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_DEPOSIT = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_RADIAL_USED = 2'd0;
  localparam logic [1:0] CFG_AXIAL_USED  = 2'd1;
  localparam logic [1:0] CFG_WEIGHT      = 2'd2;

  // fixed field widths
  localparam int CHARGE_W = 3;
  localparam int SCALE_W  = 16;
  localparam int QS_W     = CHARGE_W + SCALE_W;
  localparam int CFG_W    = 16;
  localparam int CNT_W    = 13;

  // the four cells of one deposit, in processing order
  localparam logic [1:0] SLOT_CENTRE   = 2'd0;
  localparam logic [1:0] SLOT_DIAGONAL = 2'd1;
  localparam logic [1:0] SLOT_AXIAL    = 2'd2;
  localparam logic [1:0] SLOT_RADIAL   = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SEL,
    ST_AREA,
    ST_MUL,
    ST_XADD,
    ST_DIV,
    ST_WRITE,
    ST_RD_OUT
  } cawd_state_t;

endpackage

/* hw/rtl/cawd_ram.sv */
// generic single-port-write, single-port-read memory with registered read
module cawd_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/cawd_div.sv */
// serial restoring divider, one quotient bit per cycle
module cawd_div #(
  parameter int NW = 22,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] rem_next;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          qbit;

  // one shift-subtract step
  always_comb begin
    trial    = {rem, quotient[NW-1]};
    qbit     = trial >= {1'b0, dvs};
    rem_next = qbit ? DW'(trial - {1'b0, dvs}) : DW'(trial);
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[NW-2:0], qbit};
    end
  end

endmodule

/* hw/rtl/cylindrical_area_weight_deposit.sv */
// top level: r-by-z charge grid with area-weighted deposit, read and clear
//
// Input channel (in_valid / in_stall) carries one operation per item: deposit a
// particle, read one cell, or clear one cell. Only a read gives an output item
// (out_valid / out_stall) with the cell's charge clamped to 32 bits and its sticky
// saturation flag. Configuration writes (cfg_valid / cfg_ready) are always taken.
// The grid sits in one memory; every deposit cell update is a read-modify-write.
// A read is issued to the memory in the dispatch state and its result is loaded into
// the output register in ST_RD_OUT; a clear writes zero to its cell in dispatch.
// A deposit visits up to four cells; each visited cell is selected, its area weight
// formed and multiplied, the rounding offset added, divided by 2r+1 in the serial
// divider (one quotient bit a cycle) and written back. A particle outside the grid
// ends after dispatch. One item is in work at a time. After reset a clearing pass
// writes zero to all 2^(log2 RADIAL_CELLS + log2 AXIAL_CELLS) entries while in_stall
// stays high; the configuration registers return to 64, 256 and 65535 at once.
// When the receiver stalls, a finished read result is held in the output register;
// the next item is still accepted and only a later read waits for the slot.
module cylindrical_area_weight_deposit #(
  parameter int RADIAL_CELLS      = 64,
  parameter int AXIAL_CELLS       = 256,
  parameter int FRACTION_BITS     = 16,
  parameter int ACCUMULATOR_WIDTH = 32
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   in_valid,
  output logic                                                   in_stall,
  input  logic [1:0]                                             opcode,
  input  logic [$clog2(RADIAL_CELLS)+FRACTION_BITS-1:0]          radial_position,
  input  logic [$clog2(AXIAL_CELLS)+FRACTION_BITS-1:0]           axial_position,
  input  logic signed [cawd_pkg::CHARGE_W-1:0]                   charge,
  input  logic [$clog2(RADIAL_CELLS)-1:0]                        cell_row,
  input  logic [$clog2(AXIAL_CELLS)-1:0]                         cell_column,
  output logic                                                   out_valid,
  input  logic                                                   out_stall,
  output logic signed [31:0]                                     cell_charge,
  output logic                                                   saturated,
  input  logic                                                   cfg_valid,
  output logic                                                   cfg_ready,
  input  logic [1:0]                                             cfg_index,
  input  logic [cawd_pkg::CFG_W-1:0]                             cfg_data
);

  import cawd_pkg::*;

  localparam int F      = FRACTION_BITS;
  localparam int RW     = $clog2(RADIAL_CELLS);
  localparam int ZW     = $clog2(AXIAL_CELLS);
  localparam int AW     = RW + ZW;
  localparam int ACC    = ACCUMULATOR_WIDTH;
  localparam int MW     = ACC + 1;
  localparam int AREA_W = F + 1;
  localparam int NUM_W  = QS_W + AREA_W;
  localparam int SUM_W  = NUM_W + 2;
  localparam int XW     = SUM_W - F;
  localparam int DVW    = RW + 1;
  localparam int DLW    = XW + 1;
  localparam int EW     = (ACC > 32) ? ACC : 32;
  localparam int PW     = 2 * F + 2;

  localparam logic [F:0]   ONE_F  = (F + 1)'(1) << F;
  localparam logic [F-1:0] HALF_F = F'(1) << (F - 1);

  cawd_state_t state, state_next;

  // configuration
  logic [6:0]         radial_used_cfg;
  logic [8:0]         axial_used_cfg;
  logic [SCALE_W-1:0] weight_scale;

  // captured item
  logic [1:0]            op_r;
  logic [RW+F-1:0]       rpos_r;
  logic [ZW+F-1:0]       zpos_r;
  logic [CHARGE_W-1:0]   q_r;
  logic [RW-1:0]         row_r;
  logic [ZW-1:0]         col_r;

  // deposit geometry
  logic [RW-1:0]  rc_r, rn_r, cur_r;
  logic [ZW-1:0]  zc_r, zn_r, cur_z;
  logic [F-1:0]   ksi_r, eta_r;
  logic           rok_r, zok_r, qneg_r, rd_inside_r;
  logic [QS_W-1:0] qaws_r;
  logic [1:0]     idx;
  logic [AREA_W-1:0] area_r;
  logic [NUM_W-1:0]  num_r;
  logic [AW-1:0]     clr_addr;

  // geometry from the captured item
  logic [CNT_W-1:0]  r_used, z_used;
  logic [RW-1:0]     rc;
  logic [ZW-1:0]     zc;
  logic [F-1:0]      fr, fz, ksi, eta;
  logic              top, right, grid_in, cell_in;
  logic [CHARGE_W-1:0] qa;

  // selected cell of the sequence
  logic [RW-1:0]     tr;
  logic [ZW-1:0]     tz;
  logic [AREA_W-1:0] wa, wb;
  logic              slot_en;
  logic [PW-1:0]     area_prod;

  // update arithmetic
  logic [SUM_W-1:0]  xsum;
  logic              div_start, div_done;
  logic [XW-1:0]     mag;
  logic [DLW-1:0]    delta;
  logic signed [MW-1:0] old_ext, acc_sum;
  logic [ACC-1:0]    acc_new;
  logic              sat_new;
  logic signed [EW-1:0] rd_ext;
  logic [31:0]       rd_clamp;

  // memory ports
  logic          wr_en, rd_en, out_load;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [MW-1:0] wr_data, rd_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radial_used_cfg <= 7'd64;
      axial_used_cfg  <= 9'd256;
      weight_scale    <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIAL_USED: radial_used_cfg <= cfg_data[6:0];
        CFG_AXIAL_USED:  axial_used_cfg  <= cfg_data[8:0];
        CFG_WEIGHT:      weight_scale    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry of the captured particle
  always_comb begin
    r_used  = (CNT_W'(radial_used_cfg) < CNT_W'(RADIAL_CELLS)) ?
              CNT_W'(radial_used_cfg) : CNT_W'(RADIAL_CELLS);
    z_used  = (CNT_W'(axial_used_cfg) < CNT_W'(AXIAL_CELLS)) ?
              CNT_W'(axial_used_cfg) : CNT_W'(AXIAL_CELLS);
    rc      = rpos_r[RW+F-1:F];
    zc      = zpos_r[ZW+F-1:F];
    fr      = rpos_r[F-1:0];
    fz      = zpos_r[F-1:0];
    top     = fr[F-1];
    right   = fz[F-1];
    ksi     = top ? F'(fr - HALF_F) : F'(HALF_F - fr);
    eta     = right ? F'(fz - HALF_F) : F'(HALF_F - fz);
    grid_in = (CNT_W'(rc) < r_used) && (CNT_W'(zc) < z_used);
    cell_in = (CNT_W'(row_r) < CNT_W'(RADIAL_CELLS)) &&
              (CNT_W'(col_r) < CNT_W'(AXIAL_CELLS));
    qa      = q_r[CHARGE_W-1] ? CHARGE_W'(~q_r + 1'b1) : q_r;
  end

  // target cell and weight pair of the current slot
  always_comb begin
    tr      = rc_r;
    tz      = zc_r;
    wa      = AREA_W'(ONE_F - AREA_W'(ksi_r));
    wb      = AREA_W'(ONE_F - AREA_W'(eta_r));
    slot_en = 1'b1;
    case (idx)
      SLOT_CENTRE: begin
      end
      SLOT_DIAGONAL: begin
        tr      = rn_r;
        tz      = zn_r;
        wa      = AREA_W'(ksi_r);
        wb      = AREA_W'(eta_r);
        slot_en = rok_r && zok_r;
      end
      SLOT_AXIAL: begin
        tz      = zn_r;
        wb      = AREA_W'(eta_r);
        slot_en = zok_r;
      end
      SLOT_RADIAL: begin
        tr      = rn_r;
        wa      = AREA_W'(ksi_r);
        slot_en = rok_r;
      end
      default: ;
    endcase
    area_prod = PW'(wa) * PW'(wb) + PW'(HALF_F);
  end

  // rounding offset, saturating accumulate and 32-bit clamp of the read value
  always_comb begin
    xsum    = SUM_W'({num_r, 1'b0}) + (SUM_W'({cur_r, 1'b1}) << (F - 1));
    delta   = qneg_r ? DLW'(DLW'(0) - {1'b0, mag}) : {1'b0, mag};
    old_ext = MW'($signed(rd_data[ACC-1:0]));
    acc_sum = old_ext + MW'($signed(delta));
    acc_new = acc_sum[ACC-1:0];
    sat_new = rd_data[ACC];
    if (acc_sum[ACC] != acc_sum[ACC-1]) begin
      sat_new = 1'b1;
      acc_new = acc_sum[ACC] ? {1'b1, {(ACC-1){1'b0}}} : {1'b0, {(ACC-1){1'b1}}};
    end
    rd_ext = EW'($signed(rd_data[ACC-1:0]));
    if ((&rd_ext[EW-1:31]) || !(|rd_ext[EW-1:31])) begin
      rd_clamp = rd_ext[31:0];
    end else begin
      rd_clamp = rd_ext[EW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = {cur_r, cur_z};
    wr_data    = {sat_new, acc_new};
    rd_en      = 1'b0;
    rd_addr    = {tr, tz};
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (&clr_addr) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        rd_addr = {row_r, col_r};
        wr_addr = {row_r, col_r};
        wr_data = '0;
        case (op_r)
          OP_DEPOSIT: state_next = grid_in ? ST_SEL : ST_IDLE;
          OP_READ: begin
            rd_en      = cell_in;
            state_next = ST_RD_OUT;
          end
          OP_CLEAR: begin
            wr_en      = cell_in;
            state_next = ST_IDLE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_SEL: begin
        if (slot_en) begin
          state_next = ST_AREA;
        end else if (idx == SLOT_RADIAL) begin
          state_next = ST_IDLE;
        end
      end
      ST_AREA: begin
        rd_en      = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: state_next = ST_XADD;
      ST_XADD: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        wr_en      = 1'b1;
        state_next = (idx == SLOT_RADIAL) ? ST_IDLE : ST_SEL;
      end
      ST_RD_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= SLOT_CENTRE;
    end else if (state == ST_DISPATCH) begin
      idx <= SLOT_CENTRE;
    end else if ((state == ST_SEL && !slot_en) || state == ST_WRITE) begin
      idx <= idx + 1'b1;
    end
  end

  // item capture and deposit datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_r   <= opcode;
      rpos_r <= radial_position;
      zpos_r <= axial_position;
      q_r    <= charge;
      row_r  <= cell_row;
      col_r  <= cell_column;
    end
    if (state == ST_DISPATCH) begin
      rc_r        <= rc;
      zc_r        <= zc;
      rn_r        <= top ? RW'(rc + 1'b1) : RW'(rc - 1'b1);
      zn_r        <= right ? ZW'(zc + 1'b1) : ZW'(zc - 1'b1);
      rok_r       <= top ? (CNT_W'(rc) + CNT_W'(2) < r_used) : (rc != '0);
      zok_r       <= right ? (CNT_W'(zc) + CNT_W'(2) < z_used) : (zc != '0);
      ksi_r       <= ksi;
      eta_r       <= eta;
      qneg_r      <= q_r[CHARGE_W-1];
      qaws_r      <= QS_W'(qa) * QS_W'(weight_scale);
      rd_inside_r <= cell_in;
    end
    if (state == ST_AREA) begin
      area_r <= area_prod[2*F:F];
      cur_r  <= tr;
      cur_z  <= tz;
    end
    if (state == ST_MUL) begin
      num_r <= NUM_W'(qaws_r) * NUM_W'(area_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_charge <= rd_inside_r ? rd_clamp : 32'd0;
      saturated   <= rd_inside_r ? rd_data[ACC] : 1'b0;
    end
  end

  cawd_div #(
    .NW (XW),
    .DW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (xsum[SUM_W-1:F]),
    .divisor  ({cur_r, 1'b1}),
    .done     (div_done),
    .quotient (mag)
  );

  cawd_ram #(
    .WIDTH (MW),
    .DEPTH (1 << AW)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

/* test/tb.sv */
// self-checking testbench for the cylindrical area weight deposit block
`timescale 1ns / 1ps

module tb;
  import cawd_pkg::*;

  localparam int RCELLS = 64;
  localparam int ZCELLS = 256;
  localparam int FB = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 200;

  typedef struct {
    logic [1:0] op;
    logic [21:0] rpos;
    logic [23:0] zpos;
    logic signed [2:0] q;
    logic [5:0] row;
    logic [7:0] col;
    bit typed;
    logic signed [31:0] t_charge;
    logic t_sat;
  } stim_row_t;

  typedef struct {
    logic signed [31:0] q;
    logic s;
  } cell_read_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] opcode;
  logic [21:0] radial_position;
  logic [23:0] axial_position;
  logic signed [2:0] charge;
  logic [5:0] cell_row;
  logic [7:0] cell_column;
  logic out_valid, out_stall;
  logic signed [31:0] cell_charge;
  logic saturated;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // predictor state
  longint grid_value [RCELLS*ZCELLS];
  bit grid_sat [RCELLS*ZCELLS];
  int unsigned r_active, z_active, scale;
  cell_read_t pending_reads [$];
  int touched_r [$];
  int touched_z [$];

  int error_count;
  int cycles;
  bit quiet;
  bit hold_req;

  cylindrical_area_weight_deposit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .radial_position(radial_position), .axial_position(axial_position),
    .charge(charge), .cell_row(cell_row), .cell_column(cell_column),
    .out_valid(out_valid), .out_stall(out_stall),
    .cell_charge(cell_charge), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // add one weighted contribution to a cell, saturating
  function automatic void add_to_grid(int r, int z, longint unsigned area, int q);
    longint unsigned qa, num, den, mag;
    longint delta, sum;
    int idx;
    if (r >= RCELLS || z >= ZCELLS) return;
    qa = (q < 0) ? -q : q;
    num = qa * scale * area * 2;
    den = longint'(2 * r + 1) << FB;
    mag = (num + den / 2) / den;
    delta = (q < 0) ? -longint'(mag) : longint'(mag);
    idx = r * ZCELLS + z;
    sum = grid_value[idx] + delta;
    if (sum > ACC_HI) begin sum = ACC_HI; grid_sat[idx] = 1'b1; end
    if (sum < ACC_LO) begin sum = ACC_LO; grid_sat[idx] = 1'b1; end
    grid_value[idx] = sum;
  endfunction

  function automatic longint unsigned overlap(longint unsigned a, longint unsigned b);
    return (a * b + (1 << (FB - 1))) >> FB;
  endfunction

  // spread one particle over up to four cells
  function automatic void deposit_particle(logic [21:0] rp, logic [23:0] zp, int q);
    int ru, zu, rc, zc, rn, zn;
    longint unsigned fr, fz, ksi, eta, one, half;
    bit top, right, r_ok, z_ok;
    one = 1 << FB;
    half = 1 << (FB - 1);
    ru = (r_active < RCELLS) ? r_active : RCELLS;
    zu = (z_active < ZCELLS) ? z_active : ZCELLS;
    rc = rp >> FB;
    zc = zp >> FB;
    fr = rp[FB-1:0];
    fz = zp[FB-1:0];
    top = fr >= half;
    right = fz >= half;
    ksi = top ? fr - half : half - fr;
    eta = right ? fz - half : half - fz;
    if (rc >= ru || zc >= zu) return;
    r_ok = top ? (rc + 2 < ru) : (rc > 0);
    z_ok = right ? (zc + 2 < zu) : (zc > 0);
    rn = top ? rc + 1 : rc - 1;
    zn = right ? zc + 1 : zc - 1;
    add_to_grid(rc, zc, overlap(one - ksi, one - eta), q);
    if (r_ok && z_ok) add_to_grid(rn, zn, overlap(ksi, eta), q);
    if (z_ok) add_to_grid(rc, zn, overlap(eta, one - ksi), q);
    if (r_ok) add_to_grid(rn, zc, overlap(ksi, one - eta), q);
    touched_r.push_back(rc);
    touched_z.push_back(zc);
    if (touched_r.size() > 16) begin
      void'(touched_r.pop_front());
      void'(touched_z.pop_front());
    end
  endfunction

  // apply one accepted item; returns 1 with the cell contents for a read
  function automatic bit apply_item(stim_row_t it, output cell_read_t res);
    int idx;
    longint v;
    res.q = '0;
    res.s = 1'b0;
    idx = it.row * ZCELLS + it.col;
    case (it.op)
      OP_DEPOSIT: begin
        deposit_particle(it.rpos, it.zpos, int'(it.q));
        return 1'b0;
      end
      OP_READ: begin
        v = grid_value[idx];
        if (v > ACC_HI) v = ACC_HI;
        if (v < ACC_LO) v = ACC_LO;
        res.q = v[31:0];
        res.s = grid_sat[idx];
        return 1'b1;
      end
      OP_CLEAR: begin
        grid_value[idx] = 0;
        grid_sat[idx] = 1'b0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // offer one item, wait for acceptance, record what it should produce
  task automatic send_item(stim_row_t it);
    int gap;
    cell_read_t res;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) in_valid = 1'b0;
    repeat (gap) @(negedge clk);
    opcode = it.op;
    radial_position = it.rpos;
    axial_position = it.zpos;
    charge = it.q;
    cell_row = it.row;
    cell_column = it.col;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (apply_item(it, res)) begin
      if (it.typed) begin
        res.q = it.t_charge;
        res.s = it.t_sat;
      end
      pending_reads.push_back(res);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RADIAL_USED: r_active = val[6:0];
      CFG_AXIAL_USED: z_active = val[8:0];
      CFG_WEIGHT: scale = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait until the block has drained, then set a new grid size and scale
  task automatic reconfigure(int unsigned rr, int unsigned zz, int unsigned ws);
    in_valid = 1'b0;
    wait (pending_reads.size() == 0);
    repeat (SETTLE) @(negedge clk);
    write_reg(CFG_RADIAL_USED, rr);
    write_reg(CFG_AXIAL_USED, zz);
    write_reg(CFG_WEIGHT, ws);
  endtask

  function automatic stim_row_t make_row(logic [1:0] op, logic [21:0] rp, logic [23:0] zp,
                                         int q, int r, int c);
    stim_row_t it;
    it.op = op;
    it.rpos = rp;
    it.zpos = zp;
    it.q = q;
    it.row = r;
    it.col = c;
    it.typed = 1'b0;
    it.t_charge = '0;
    it.t_sat = 1'b0;
    return it;
  endfunction

  function automatic stim_row_t typed_read(int r, int c, logic signed [31:0] v, logic s);
    stim_row_t it;
    it = make_row(OP_READ, '0, '0, 0, r, c);
    it.typed = 1'b1;
    it.t_charge = v;
    it.t_sat = s;
    return it;
  endfunction

  // random item, mostly inside the active grid and near recent deposits
  function automatic stim_row_t random_item();
    stim_row_t it;
    int pick, ru, zu, k;
    ru = (r_active < RCELLS) ? r_active : RCELLS;
    zu = (z_active < ZCELLS) ? z_active : ZCELLS;
    if (ru == 0) ru = 1;
    if (zu == 0) zu = 1;
    it = make_row(OP_DEPOSIT, $urandom, $urandom, $urandom_range(0, 7),
                  $urandom_range(0, 63), $urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 4) != 0) begin
        it.rpos[21:16] = $urandom_range(0, ru - 1);
        it.zpos[23:16] = $urandom_range(0, zu - 1);
        case ($urandom_range(0, 5))
          0: it.rpos[15:0] = 16'h8000;
          1: it.zpos[15:0] = 16'h0000;
          2: it.rpos[15:0] = 16'hFFFF;
          default: ;
        endcase
      end
    end else if (pick < 92) begin
      it.op = (pick < 80) ? OP_READ : OP_CLEAR;
      if (touched_r.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = $urandom_range(0, touched_r.size() - 1);
        it.row = touched_r[k] + $urandom_range(0, 1);
        it.col = touched_z[k] + $urandom_range(0, 2) - 1;
      end
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // receiver: random stalls per item, one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      n = quiet ? 0 : $urandom_range(0, 11);
      out_stall = (n != 0);
      repeat (n) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checker
  always @(posedge clk) begin
    cell_read_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected item: cell_charge %0d saturated %0d", cell_charge, saturated);
        error_count++;
      end else begin
        want = pending_reads.pop_front();
        if (cell_charge !== want.q) begin
          $error("cell_charge: expected %0d, got %0d", want.q, cell_charge);
          error_count++;
        end
        if (saturated !== want.s) begin
          $error("saturated: expected %0d, got %0d", want.s, saturated);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t directed [$];
    stim_row_t it;
    int phase, n;
    int unsigned ws;
    error_count = 0;
    cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_DEPOSIT;
    radial_position = '0;
    axial_position = '0;
    charge = '0;
    cell_row = '0;
    cell_column = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RADIAL_USED;
    cfg_data = '0;
    foreach (grid_value[i]) begin
      grid_value[i] = 0;
      grid_sat[i] = 1'b0;
    end
    r_active = 64;
    z_active = 256;
    scale = 65535;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows: reset contents, extremes, every operation, edges
    directed.push_back(typed_read(0, 0, 0, 0));
    directed.push_back(typed_read(63, 255, 0, 0));
    directed.push_back(make_row(OP_DEPOSIT, 22'h008000, 24'h008000, 2, 0, 0));
    directed.push_back(typed_read(0, 0, 262140, 0));
    directed.push_back(make_row(OP_DEPOSIT, 22'h008000, 24'h008000, -2, 0, 0));
    directed.push_back(typed_read(0, 0, 0, 0));
    directed.push_back(make_row(OP_DEPOSIT, 22'h3FFFFF, 24'hFFFFFF, 3, 0, 0));
    directed.push_back(make_row(OP_DEPOSIT, 22'h000000, 24'h000000, -4, 0, 0));
    directed.push_back(make_row(OP_DEPOSIT, 22'h054321, 24'h12ABCD, -3, 0, 0));
    directed.push_back(make_row(OP_READ, '0, '0, 0, 63, 255));
    directed.push_back(make_row(OP_READ, '0, '0, 0, 0, 0));
    directed.push_back(make_row(OP_READ, '0, '0, 0, 5, 18));
    directed.push_back(make_row(OP_READ, '0, '0, 0, 5, 19));
    directed.push_back(make_row(OP_UNUSED, 22'h3FFFFF, 24'hFFFFFF, -1, 63, 255));
    directed.push_back(make_row(OP_CLEAR, '0, '0, 0, 63, 255));
    directed.push_back(typed_read(63, 255, 0, 0));
    directed.push_back(make_row(OP_CLEAR, '0, '0, 0, 0, 0));
    directed.push_back(typed_read(0, 0, 0, 0));
    foreach (directed[i]) send_item(directed[i]);

    // small grid: edge and outside deposits
    reconfigure(2, 2, 65535);
    it = make_row(OP_DEPOSIT, 22'h028000, 24'h008000, 1, 0, 0);
    send_item(it);
    it = make_row(OP_DEPOSIT, 22'h008000, 24'h018000, 1, 0, 0);
    send_item(it);
    send_item(typed_read(0, 1, 131070, 0));
    send_item(make_row(OP_CLEAR, '0, '0, 0, 0, 1));
    send_item(typed_read(0, 1, 0, 0));

    // random phases over several grid sizes and scales
    for (phase = 0; phase < 6; phase++) begin
      ws = $urandom_range(0, 65535);
      case (phase)
        0: reconfigure(64, 256, 65535);
        1: reconfigure(2, 2, 0);
        2: reconfigure(5, 9, ws);
        3: reconfigure(127, 511, ws);
        4: reconfigure($urandom_range(0, 127), $urandom_range(0, 511), ws);
        default: reconfigure($urandom_range(2, 12), $urandom_range(2, 20), 1);
      endcase
      quiet = (phase == 2);
      n = 0;
      while (n < 60) begin
        it = random_item();
        if (it.op != OP_UNUSED) n++;
        send_item(it);
      end
      // long receiver hold-off while reads keep coming
      if (phase == 3) begin
        hold_req = 1'b1;
        repeat (12) send_item(make_row(OP_READ, '0, '0, 0, $urandom_range(0, 63),
                                       $urandom_range(0, 255)));
      end
    end

    in_valid = 1'b0;
    wait (pending_reads.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cawd_pkg.sv
hw/rtl/cawd_ram.sv
hw/rtl/cawd_div.sv
hw/rtl/cylindrical_area_weight_deposit.sv
test/tb.sv
